/* sv/acs_pkg.sv */
package acs_pkg;

    // Longest run; the pair at index MAX_ELEMENTS-1 always closes a run.
    localparam int MAX_ELEMENTS = 1048576;
    localparam int LOG_W        = $clog2(MAX_ELEMENTS);
    // Counters hold MAX_ELEMENTS itself.
    localparam int CNT_W        = LOG_W + 1;
    // Difference sum: 32-bit magnitudes over the whole run.
    localparam int DSUM_W       = 33 + LOG_W;
    // Element sum: 33-bit signed elements over the whole run.
    localparam int ASUM_W       = 34 + LOG_W;
    localparam int IDX_W        = 20;

    localparam logic [20:0] MAXREP_RESET = 21'h10_0000;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_WORD = 1'b1;

    typedef enum logic [2:0] {
        ET_INT8, ET_UINT8, ET_INT16, ET_UINT16, ET_INT32, ET_UINT32
    } t_elem;

    typedef enum logic [2:0] {
        CFG_TYPE, CFG_LIMIT, CFG_MAXREP, CFG_FA_EN, CFG_FA_VAL, CFG_FB_EN, CFG_FB_VAL
    } t_cfg_idx;

    typedef enum logic [3:0] {
        W_NDIFF, W_NSTATS, W_DSUM, W_DMAX, W_AMIN, W_AMAX, W_BMIN, W_BMAX,
        W_ASUM, W_BSUM, W_ASQ, W_BSQ, W_XSUM
    } t_word;

    typedef struct packed {
        logic [2:0]         element_type;
        logic [31:0]        error_limit;
        logic [20:0]        max_reported;
        logic               fill_a_en;
        logic signed [32:0] fill_a_value;
        logic               fill_b_en;
        logic signed [32:0] fill_b_value;
        logic               type_wr;
    } t_cfg;

    typedef struct packed {
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic               fa;
        logic               fb;
        logic [31:0]        diff;
        logic               exceeds;
        logic [63:0]        sq_a;
        logic [63:0]        sq_b;
        logic [63:0]        xprod;
        logic               xneg;
    } t_pair;

    // Sign or zero extension of the low 8, 16 or 32 bits per element type.
    function automatic logic signed [32:0] extend(input logic [32:0] raw,
                                                  input logic [2:0] typ);
        unique case (t_elem'(typ))
            ET_INT8:   return {{25{raw[7]}}, raw[7:0]};
            ET_UINT8:  return {25'd0, raw[7:0]};
            ET_INT16:  return {{17{raw[15]}}, raw[15:0]};
            ET_UINT16: return {17'd0, raw[15:0]};
            ET_INT32:  return {raw[31], raw[31:0]};
            default:   return {1'b0, raw[31:0]};
        endcase
    endfunction

    function automatic logic signed [32:0] type_lo(input logic [2:0] typ);
        unique case (t_elem'(typ))
            ET_INT8:  return -33'sd128;
            ET_INT16: return -33'sd32768;
            ET_INT32: return -33'sd2147483648;
            default:  return 33'sd0;
        endcase
    endfunction

    function automatic logic signed [32:0] type_hi(input logic [2:0] typ);
        unique case (t_elem'(typ))
            ET_INT8:   return 33'sd127;
            ET_UINT8:  return 33'sd255;
            ET_INT16:  return 33'sd32767;
            ET_UINT16: return 33'sd65535;
            ET_INT32:  return 33'sd2147483647;
            default:   return 33'sd4294967295;
        endcase
    endfunction

    // Signed 64-bit accumulate of a 64-bit magnitude, clamped to the range.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] acc,
                                                   input logic neg,
                                                   input logic [63:0] mag);
        logic [65:0] m;
        logic [65:0] s;
        m = {2'b00, mag};
        if (neg) begin
            m = 66'd0 - m;
        end
        s = {{2{acc[63]}}, acc} + m;
        if (s[65:63] == 3'b000 || s[65:63] == 3'b111) begin
            return s[63:0];
        end else if (s[65]) begin
            return S64_MIN;
        end else begin
            return S64_MAX;
        end
    endfunction

endpackage

/* sv/acs_in_if.sv */
interface acs_in_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] value_a;
    logic signed [32:0] value_b;
    logic               final_pair;

    modport source(output valid, output value_a, output value_b, output final_pair,
                   input ready);
    modport sink(input valid, input value_a, input value_b, input final_pair,
                 output ready);
endinterface

/* sv/acs_out_if.sv */
interface acs_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [19:0]        pair_index;
    logic               exceeds;
    logic               report;
    logic [3:0]         word_id;
    logic signed [63:0] word_value;
    logic               run_end;

    modport source(output valid, output kind, output pair_index, output exceeds,
                   output report, output word_id, output word_value, output run_end,
                   input ready);
    modport sink(input valid, input kind, input pair_index, input exceeds,
                 input report, input word_id, input word_value, input run_end,
                 output ready);
endinterface

/* sv/acs_cfg_if.sv */
interface acs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [32:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/acs_cfg.sv */
module acs_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    acs_cfg_if.sink         i_cfg,
    output acs_pkg::t_cfg   o_cfg
);

    acs_pkg::t_cfg r_cfg;
    logic          wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.element_type <= acs_pkg::ET_INT32;
            r_cfg.error_limit  <= 32'd0;
            r_cfg.max_reported <= acs_pkg::MAXREP_RESET;
            r_cfg.fill_a_en    <= 1'b0;
            r_cfg.fill_a_value <= 33'sd0;
            r_cfg.fill_b_en    <= 1'b0;
            r_cfg.fill_b_value <= 33'sd0;
            r_cfg.type_wr      <= 1'b0;
        end else begin
            // The type pulse lets the accumulators reload their extremes.
            r_cfg.type_wr <= wr && (acs_pkg::t_cfg_idx'(i_cfg.index) == acs_pkg::CFG_TYPE);
            if (wr) begin
                unique case (acs_pkg::t_cfg_idx'(i_cfg.index))
                    acs_pkg::CFG_TYPE:   r_cfg.element_type <= i_cfg.data[2:0];
                    acs_pkg::CFG_LIMIT:  r_cfg.error_limit  <= i_cfg.data[31:0];
                    acs_pkg::CFG_MAXREP: r_cfg.max_reported <= i_cfg.data[20:0];
                    acs_pkg::CFG_FA_EN:  r_cfg.fill_a_en    <= i_cfg.data[0];
                    acs_pkg::CFG_FA_VAL: r_cfg.fill_a_value <= i_cfg.data;
                    acs_pkg::CFG_FB_EN:  r_cfg.fill_b_en    <= i_cfg.data[0];
                    acs_pkg::CFG_FB_VAL: r_cfg.fill_b_value <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* sv/acs_front.sv */
module acs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  acs_pkg::t_cfg   i_cfg,
    acs_in_if.sink          i_in,
    output acs_pkg::t_pair  o_pair,
    output logic            o_pair_valid,
    input  logic            i_pair_ready
);

    logic                        accept;
    logic                        s2_ready;
    logic signed [32:0]          a_x;
    logic signed [32:0]          b_x;
    logic signed [32:0]          fill_a_x;
    logic signed [32:0]          fill_b_x;
    logic [33:0]                 d_x;
    logic [33:0]                 d_abs;
    logic [32:0]                 ma_x;
    logic [32:0]                 mb_x;
    logic                        last_x;
    logic [63:0]                 sq_a;
    logic [63:0]                 sq_b;
    logic [63:0]                 xprod;

    logic [acs_pkg::CNT_W-1:0]   r_cnt;
    logic                        r1_valid;
    logic signed [32:0]          r1_a;
    logic signed [32:0]          r1_b;
    logic [31:0]                 r1_ma;
    logic [31:0]                 r1_mb;
    logic [31:0]                 r1_diff;
    logic                        r1_fa;
    logic                        r1_fb;
    logic                        r1_last;
    logic [acs_pkg::IDX_W-1:0]   r1_idx;
    logic                        r2_valid;
    acs_pkg::t_pair              r2_pair;

    assign s2_ready    = !r2_valid || i_pair_ready;
    assign i_in.ready  = !r1_valid || s2_ready;
    assign accept      = i_in.valid && i_in.ready;

    assign a_x      = acs_pkg::extend(i_in.value_a, i_cfg.element_type);
    assign b_x      = acs_pkg::extend(i_in.value_b, i_cfg.element_type);
    assign fill_a_x = acs_pkg::extend(i_cfg.fill_a_value, i_cfg.element_type);
    assign fill_b_x = acs_pkg::extend(i_cfg.fill_b_value, i_cfg.element_type);

    // Difference at full width; its magnitude never exceeds 32 bits.
    assign d_x   = {a_x[32], a_x} - {b_x[32], b_x};
    assign d_abs = d_x[33] ? (34'd0 - d_x) : d_x;
    assign ma_x  = a_x[32] ? (33'd0 - a_x) : a_x;
    assign mb_x  = b_x[32] ? (33'd0 - b_x) : b_x;

    assign last_x = i_in.final_pair ||
                    (r_cnt >= acs_pkg::CNT_W'(acs_pkg::MAX_ELEMENTS - 1));

    assign sq_a  = r1_ma * r1_ma;
    assign sq_b  = r1_mb * r1_mb;
    assign xprod = r1_ma * r1_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt    <= last_x ? '0 : r_cnt + 1'b1;
                r1_valid <= 1'b1;
            end else if (s2_ready) begin
                r1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_a    <= a_x;
            r1_b    <= b_x;
            r1_ma   <= ma_x[31:0];
            r1_mb   <= mb_x[31:0];
            r1_diff <= d_abs[31:0];
            r1_fa   <= i_cfg.fill_a_en && (a_x == fill_a_x);
            r1_fb   <= i_cfg.fill_b_en && (b_x == fill_b_x);
            r1_last <= last_x;
            r1_idx  <= r_cnt[acs_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r1_valid) begin
            r2_pair.last    <= r1_last;
            r2_pair.idx     <= r1_idx;
            r2_pair.a       <= r1_a;
            r2_pair.b       <= r1_b;
            r2_pair.fa      <= r1_fa;
            r2_pair.fb      <= r1_fb;
            r2_pair.diff    <= r1_diff;
            r2_pair.exceeds <= r1_diff > i_cfg.error_limit;
            r2_pair.sq_a    <= sq_a;
            r2_pair.sq_b    <= sq_b;
            r2_pair.xprod   <= xprod;
            r2_pair.xneg    <= (r1_a[32] != r1_b[32]) && (r1_a != 33'sd0) &&
                               (r1_b != 33'sd0);
        end
    end

    assign o_pair       = r2_pair;
    assign o_pair_valid = r2_valid;

endmodule

/* sv/acs_accum.sv */
module acs_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  acs_pkg::t_cfg   i_cfg,
    input  acs_pkg::t_pair  i_pair,
    input  logic            i_pair_valid,
    output logic            o_pair_ready,
    acs_out_if.source       o_out
);

    logic                             load;
    logic [acs_pkg::CNT_W-1:0]        flag_next;
    logic                             report;
    logic signed [32:0]               pa;
    logic signed [32:0]               pb;
    logic signed [acs_pkg::ASUM_W-1:0] pa_ext;
    logic signed [acs_pkg::ASUM_W-1:0] pb_ext;
    logic signed [63:0]               word_val;

    logic                             r_ov;
    logic                             r_kind;
    logic [acs_pkg::IDX_W-1:0]        r_idx;
    logic                             r_exc;
    logic                             r_rep;
    acs_pkg::t_word                   r_wid;
    logic signed [63:0]               r_wval;
    logic                             r_end;
    logic                             r_summ;
    acs_pkg::t_word                   r_word;

    logic [acs_pkg::CNT_W-1:0]        r_flag;
    logic [acs_pkg::CNT_W-1:0]        r_nstat;
    logic [acs_pkg::DSUM_W-1:0]       r_dsum;
    logic [31:0]                      r_dmax;
    logic signed [32:0]               r_amin;
    logic signed [32:0]               r_amax;
    logic signed [32:0]               r_bmin;
    logic signed [32:0]               r_bmax;
    logic signed [acs_pkg::ASUM_W-1:0] r_asum;
    logic signed [acs_pkg::ASUM_W-1:0] r_bsum;
    logic signed [63:0]               r_asq;
    logic signed [63:0]               r_bsq;
    logic signed [63:0]               r_xsum;

    assign load         = !r_ov || o_out.ready;
    assign o_pair_ready = load && !r_summ;

    assign pa        = i_pair.a;
    assign pb        = i_pair.b;
    assign pa_ext    = acs_pkg::ASUM_W'(pa);
    assign pb_ext    = acs_pkg::ASUM_W'(pb);
    assign flag_next = r_flag + 1'b1;
    assign report    = i_pair.exceeds && (32'(flag_next) <= 32'(i_cfg.max_reported));

    always_comb begin
        unique case (r_word)
            acs_pkg::W_NDIFF:  word_val = 64'(r_flag);
            acs_pkg::W_NSTATS: word_val = 64'(r_nstat);
            acs_pkg::W_DSUM:   word_val = 64'(r_dsum);
            acs_pkg::W_DMAX:   word_val = 64'(r_dmax);
            acs_pkg::W_AMIN:   word_val = 64'(r_amin);
            acs_pkg::W_AMAX:   word_val = 64'(r_amax);
            acs_pkg::W_BMIN:   word_val = 64'(r_bmin);
            acs_pkg::W_BMAX:   word_val = 64'(r_bmax);
            acs_pkg::W_ASUM:   word_val = 64'(r_asum);
            acs_pkg::W_BSUM:   word_val = 64'(r_bsum);
            acs_pkg::W_ASQ:    word_val = r_asq;
            acs_pkg::W_BSQ:    word_val = r_bsq;
            acs_pkg::W_XSUM:   word_val = r_xsum;
            default:           word_val = 64'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_kind  <= acs_pkg::KIND_PAIR;
            r_idx   <= '0;
            r_exc   <= 1'b0;
            r_rep   <= 1'b0;
            r_wid   <= acs_pkg::W_NDIFF;
            r_wval  <= 64'sd0;
            r_end   <= 1'b0;
            r_summ  <= 1'b0;
            r_word  <= acs_pkg::W_NDIFF;
            r_flag  <= '0;
            r_nstat <= '0;
            r_dsum  <= '0;
            r_dmax  <= '0;
            r_asum  <= '0;
            r_bsum  <= '0;
            r_asq   <= 64'sd0;
            r_bsq   <= 64'sd0;
            r_xsum  <= 64'sd0;
            r_amin  <= acs_pkg::type_hi(acs_pkg::ET_INT32);
            r_bmin  <= acs_pkg::type_hi(acs_pkg::ET_INT32);
            r_amax  <= acs_pkg::type_lo(acs_pkg::ET_INT32);
            r_bmax  <= acs_pkg::type_lo(acs_pkg::ET_INT32);
        end else begin
            if (load) begin
                if (r_summ) begin
                    // Summary word; the pair index still holds the last pair.
                    r_ov   <= 1'b1;
                    r_kind <= acs_pkg::KIND_WORD;
                    r_exc  <= 1'b0;
                    r_rep  <= 1'b0;
                    r_wid  <= r_word;
                    r_wval <= word_val;
                    if (r_word == acs_pkg::W_XSUM) begin
                        r_end   <= 1'b1;
                        r_summ  <= 1'b0;
                        r_word  <= acs_pkg::W_NDIFF;
                        r_flag  <= '0;
                        r_nstat <= '0;
                        r_dsum  <= '0;
                        r_dmax  <= '0;
                        r_asum  <= '0;
                        r_bsum  <= '0;
                        r_asq   <= 64'sd0;
                        r_bsq   <= 64'sd0;
                        r_xsum  <= 64'sd0;
                        r_amin  <= acs_pkg::type_hi(i_cfg.element_type);
                        r_bmin  <= acs_pkg::type_hi(i_cfg.element_type);
                        r_amax  <= acs_pkg::type_lo(i_cfg.element_type);
                        r_bmax  <= acs_pkg::type_lo(i_cfg.element_type);
                    end else begin
                        r_end  <= 1'b0;
                        r_word <= acs_pkg::t_word'(r_word + 4'd1);
                    end
                end else if (i_pair_valid) begin
                    r_ov   <= 1'b1;
                    r_kind <= acs_pkg::KIND_PAIR;
                    r_idx  <= i_pair.idx;
                    r_exc  <= i_pair.exceeds;
                    r_rep  <= report;
                    r_wid  <= acs_pkg::W_NDIFF;
                    r_wval <= 64'sd0;
                    r_end  <= !i_pair.last;
                    if (i_pair.last) begin
                        r_summ <= 1'b1;
                        r_word <= acs_pkg::W_NDIFF;
                    end
                    if (i_pair.exceeds) begin
                        r_flag <= flag_next;
                    end
                    if (!i_pair.fa && !i_pair.fb) begin
                        r_nstat <= r_nstat + 1'b1;
                        r_dsum  <= r_dsum + acs_pkg::DSUM_W'(i_pair.diff);
                        if (i_pair.diff > r_dmax) begin
                            r_dmax <= i_pair.diff;
                        end
                        r_asum <= r_asum + pa_ext;
                        r_bsum <= r_bsum + pb_ext;
                        r_asq  <= acs_pkg::sat_add(r_asq, 1'b0, i_pair.sq_a);
                        r_bsq  <= acs_pkg::sat_add(r_bsq, 1'b0, i_pair.sq_b);
                        r_xsum <= acs_pkg::sat_add(r_xsum, i_pair.xneg, i_pair.xprod);
                    end
                    if (!i_pair.fa) begin
                        if (pa > r_amax) begin
                            r_amax <= pa;
                        end
                        if (pa < r_amin) begin
                            r_amin <= pa;
                        end
                    end
                    if (!i_pair.fb) begin
                        if (pb > r_bmax) begin
                            r_bmax <= pb;
                        end
                        if (pb < r_bmin) begin
                            r_bmin <= pb;
                        end
                    end
                end else begin
                    r_ov <= 1'b0;
                end
            end
            // A new element type brings new extremes; the user must write it only while idle, unchecked here.
            if (i_cfg.type_wr) begin
                r_amin <= acs_pkg::type_hi(i_cfg.element_type);
                r_bmin <= acs_pkg::type_hi(i_cfg.element_type);
                r_amax <= acs_pkg::type_lo(i_cfg.element_type);
                r_bmax <= acs_pkg::type_lo(i_cfg.element_type);
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_kind;
    assign o_out.pair_index = r_idx;
    assign o_out.exceeds    = r_exc;
    assign o_out.report     = r_rep;
    assign o_out.word_id    = r_wid;
    assign o_out.word_value = r_wval;
    assign o_out.run_end    = r_end;

endmodule

/* sv/array_compare_statistics_core.sv */
// Array compare statistics core. Pairs of elements from two integer arrays
// enter on i_in, one pair per clock when the output side keeps up and no
// summary words are being sent; each pair yields one per-pair word (absolute
// difference flag and report mark) that passes both front registers and the
// output register on its way to o_out. The pair flagged by final_pair, or the
// pair at index MAX_ELEMENTS-1, is followed by thirteen summary words, one per
// cycle while the sink is ready, after which all run statistics clear. While
// those thirteen words are sent, no per-pair word leaves, so a run of N pairs
// yields N + 13 words; the input keeps accepting until its two front stages
// are full. One pair per cycle holds because each of the three registers on
// the path passes its word on in the same cycle as it takes the next one; the
// three 32 by 32 bit multipliers between the first and the second register,
// which produce the squared and cross products for the saturating 64-bit
// sums, form the longest path. Configuration writes take effect at once and
// must only be issued while the block is idle.
module array_compare_statistics_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acs_in_if.sink      i_in,
    acs_out_if.source   o_out,
    acs_cfg_if.sink     i_cfg
);

    // Register values shared by both halves of the datapath.
    acs_pkg::t_cfg  cfg;

    // Pair after extension, difference and products, ready for accumulation.
    acs_pkg::t_pair pair;
    logic           pair_valid;
    logic           pair_ready;

    // Configuration registers; the port never stalls.
    acs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Extension, difference and magnitudes, the input register, then the products.
    acs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in         (i_in),
        .o_pair       (pair),
        .o_pair_valid (pair_valid),
        .i_pair_ready (pair_ready)
    );

    // Run accumulators, output register and the summary word sequencer.
    acs_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pair       (pair),
        .i_pair_valid (pair_valid),
        .o_pair_ready (pair_ready),
        .o_out        (o_out)
    );

endmodule

/* tb/sv/array_compare_statistics_core_tb.sv */
`timescale 1ns / 100ps

module array_compare_statistics_core_tb;
    import acs_pkg::*;

    typedef longint unsigned u64_t;

    // One result word as it leaves the block, in port order.
    typedef struct packed {
        logic               kind;
        logic [19:0]        pair_index;
        logic               exceeds;
        logic               report;
        logic [3:0]         word_id;
        logic signed [63:0] word_value;
        logic               run_end;
    } word_rec_t;

    // Type codes 6 and 7 have no name in the package; both behave as uint32.
    localparam logic [2:0]  TYPE_SPARE_LO = 3'd6;
    localparam logic [2:0]  TYPE_SPARE_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int          DRAIN_CYCLES  = 16;

    // Tracks the run statistics of the block and keeps the words it owes.
    class pair_stats_tracker;
        logic [2:0]  elem_type;
        logic [31:0] diff_thresh;
        logic [20:0] max_rep;
        logic        fill_a_on;
        logic        fill_b_on;
        logic [32:0] fill_a;
        logic [32:0] fill_b;
        int unsigned pair_cnt;
        int unsigned flag_cnt;
        int unsigned stat_cnt;
        u64_t        diff_total;
        u64_t        diff_peak;
        longint      a_lo, a_hi, b_lo, b_hi;
        longint      a_total, b_total, a_sq, b_sq, ab_sum;
        word_rec_t   due_words[$];
        int          faults;

        function new();
            elem_type   = ET_INT32;
            diff_thresh = '0;
            max_rep     = MAXREP_RESET;
            fill_a_on   = 1'b0;
            fill_b_on   = 1'b0;
            fill_a      = '0;
            fill_b      = '0;
            faults      = 0;
            restart_run();
        endfunction

        function longint widen(logic [32:0] raw);
            case (elem_type)
                ET_INT8:   return longint'($signed(raw[7:0]));
                ET_UINT8:  return longint'(raw[7:0]);
                ET_INT16:  return longint'($signed(raw[15:0]));
                ET_UINT16: return longint'(raw[15:0]);
                ET_INT32:  return longint'($signed(raw[31:0]));
                default:   return longint'(raw[31:0]);
            endcase
        endfunction

        function void load_bounds();
            longint lo;
            longint hi;
            case (elem_type)
                ET_INT8:   begin lo = -128;               hi = 127;               end
                ET_UINT8:  begin lo = 0;                  hi = 255;               end
                ET_INT16:  begin lo = -32768;             hi = 32767;             end
                ET_UINT16: begin lo = 0;                  hi = 65535;             end
                ET_INT32:  begin lo = -64'sd2147483648;   hi = 64'sd2147483647;   end
                default:   begin lo = 0;                  hi = 64'sd4294967295;   end
            endcase
            a_lo = hi;
            b_lo = hi;
            a_hi = lo;
            b_hi = lo;
        endfunction

        function void restart_run();
            pair_cnt   = 0;
            flag_cnt   = 0;
            stat_cnt   = 0;
            diff_total = 0;
            diff_peak  = 0;
            a_total    = 0;
            b_total    = 0;
            a_sq       = 0;
            b_sq       = 0;
            ab_sum     = 0;
            load_bounds();
        endfunction

        // Adds or subtracts a magnitude and clamps to the signed 64-bit range.
        function longint sat_sum(longint acc, bit neg, u64_t mag);
            logic signed [65:0] t;
            t = acc;
            if (neg) begin
                t = t - $signed({2'b00, mag});
            end else begin
                t = t + $signed({2'b00, mag});
            end
            if (t > S64_MAX) begin
                return S64_MAX;
            end
            if (t < S64_MIN) begin
                return S64_MIN;
            end
            return t[63:0];
        endfunction

        function void take_setting(t_cfg_idx idx, logic [32:0] data);
            case (idx)
                CFG_TYPE: begin
                    elem_type = data[2:0];
                    load_bounds();
                end
                CFG_LIMIT:  diff_thresh = data[31:0];
                CFG_MAXREP: max_rep     = data[20:0];
                CFG_FA_EN:  fill_a_on   = data[0];
                CFG_FA_VAL: fill_a      = data;
                CFG_FB_EN:  fill_b_on   = data[0];
                CFG_FB_VAL: fill_b      = data;
                default: ;
            endcase
        endfunction

        function void take_pair(logic [32:0] raw_a, logic [32:0] raw_b, logic fin);
            longint    a;
            longint    b;
            u64_t      diff;
            u64_t      mag_a;
            u64_t      mag_b;
            bit        last_pair;
            bit        skip_a;
            bit        skip_b;
            bit        over;
            bit        rep;
            word_rec_t r;
            longint    vals[13];
            a         = widen(raw_a);
            b         = widen(raw_b);
            last_pair = fin || (pair_cnt >= MAX_ELEMENTS - 1);
            skip_a    = fill_a_on && (a == widen(fill_a));
            skip_b    = fill_b_on && (b == widen(fill_b));
            diff      = (a > b) ? u64_t'(a - b) : u64_t'(b - a);
            over      = diff > u64_t'(diff_thresh);
            rep       = 1'b0;
            mag_a     = (a < 0) ? u64_t'(-a) : u64_t'(a);
            mag_b     = (b < 0) ? u64_t'(-b) : u64_t'(b);

            if (over) begin
                flag_cnt++;
                rep = flag_cnt <= max_rep;
            end
            if (!skip_a && !skip_b) begin
                diff_total += diff;
                if (diff > diff_peak) begin
                    diff_peak = diff;
                end
                a_total += a;
                b_total += b;
                a_sq    = sat_sum(a_sq, 1'b0, mag_a * mag_a);
                b_sq    = sat_sum(b_sq, 1'b0, mag_b * mag_b);
                ab_sum  = sat_sum(ab_sum, ((a < 0) != (b < 0)) && a != 0 && b != 0,
                                  mag_a * mag_b);
                stat_cnt++;
            end
            if (!skip_a) begin
                if (a > a_hi) a_hi = a;
                if (a < a_lo) a_lo = a;
            end
            if (!skip_b) begin
                if (b > b_hi) b_hi = b;
                if (b < b_lo) b_lo = b;
            end

            r            = '0;
            r.kind       = KIND_PAIR;
            r.pair_index = pair_cnt[19:0];
            r.exceeds    = over;
            r.report     = rep;
            r.run_end    = !last_pair;
            due_words.push_back(r);
            pair_cnt++;
            if (!last_pair) begin
                return;
            end

            vals[W_NDIFF]  = flag_cnt;
            vals[W_NSTATS] = stat_cnt;
            vals[W_DSUM]   = diff_total;
            vals[W_DMAX]   = diff_peak;
            vals[W_AMIN]   = a_lo;
            vals[W_AMAX]   = a_hi;
            vals[W_BMIN]   = b_lo;
            vals[W_BMAX]   = b_hi;
            vals[W_ASUM]   = a_total;
            vals[W_BSUM]   = b_total;
            vals[W_ASQ]    = a_sq;
            vals[W_BSQ]    = b_sq;
            vals[W_XSUM]   = ab_sum;
            for (int k = 0; k < 13; k++) begin
                r.kind       = KIND_WORD;
                r.exceeds    = 1'b0;
                r.report     = 1'b0;
                r.word_id    = k[3:0];
                r.word_value = vals[k];
                r.run_end    = (k == W_XSUM);
                due_words.push_back(r);
            end
            restart_run();
        endfunction

        function int outstanding();
            return due_words.size();
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                faults++;
            end
        endfunction

        function void match_word(word_rec_t seen);
            word_rec_t want;
            if (due_words.size() == 0) begin
                $error("unexpected result word: kind %0d, pair_index %0d",
                       seen.kind, seen.pair_index);
                faults++;
                return;
            end
            want = due_words.pop_front();
            check_field("kind",       want.kind,       seen.kind);
            check_field("pair_index", want.pair_index, seen.pair_index);
            check_field("exceeds",    want.exceeds,    seen.exceeds);
            check_field("report",     want.report,     seen.report);
            check_field("word_id",    want.word_id,    seen.word_id);
            check_field("word_value", want.word_value, seen.word_value);
            check_field("run_end",    want.run_end,    seen.run_end);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    acs_in_if  in_ch();
    acs_out_if out_ch();
    acs_cfg_if cfg_ch();

    array_compare_statistics_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pair_stats_tracker tracker = new();

    // Idle chances in percent per cycle for the input and output sides.
    int          snd_idle_pct = 16;
    int          rcv_idle_pct = 63;
    // Set while an input word may still be presented; cleared when settle_input lowers valid.
    bit          in_busy      = 1'b0;
    int unsigned cycle_count  = 0;
    word_rec_t   seen;

    // The stimulus keeps its own view of the element type and the fill values
    // so that it can aim elements at type extremes and at masked entries.
    logic [2:0]  cur_type   = ET_INT32;
    logic [32:0] cur_fill_a = '0;
    logic [32:0] cur_fill_b = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Output side: every word accepted is checked against the oldest
    // expectation, and ready is redrawn each cycle from the current idle chance.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            seen.kind       = out_ch.kind;
            seen.pair_index = out_ch.pair_index;
            seen.exceeds    = out_ch.exceeds;
            seen.report     = out_ch.report;
            seen.word_id    = out_ch.word_id;
            seen.word_value = out_ch.word_value;
            seen.run_end    = out_ch.run_end;
            tracker.match_word(seen);
        end
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // A watchdog, so that a hung handshake cannot stall the run for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("array_compare_statistics_core verification failed");
            $finish;
        end
    end

    // Presents one pair and waits for its acceptance. Valid is left high, so
    // that a following word can go out on the very next cycle; settle_input
    // lowers it when the stream pauses.
    task automatic send_pair(logic [32:0] a, logic [32:0] b, logic fin);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value_a    <= a;
        in_ch.value_b    <= b;
        in_ch.final_pair <= fin;
        in_busy = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.take_pair(a, b, fin);
    endtask

    // Stops the input stream and waits until every owed word has come out.
    // Every pair yields at least one word, so an empty queue means idle.
    task automatic settle_input();
        if (in_busy) begin
            in_ch.valid <= 1'b0;
            in_busy = 1'b0;
        end
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Register writes keep valid high across a burst; cfg_release ends it.
    task automatic write_reg(t_cfg_idx idx, logic [32:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        tracker.take_setting(idx, data);
        case (idx)
            CFG_TYPE:   cur_type   = data[2:0];
            CFG_FA_VAL: cur_fill_a = data;
            CFG_FB_VAL: cur_fill_b = data;
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_ch.valid <= 1'b0;
    endtask

    // Picks an element: type extremes, zero, one, the fill value or noise,
    // with random bits above the element width that the block must ignore.
    function automatic logic [32:0] pick_elem(logic [32:0] fill);
        int          w;
        logic [32:0] raw;
        logic [32:0] mask;
        logic [32:0] pat;
        case (cur_type)
            ET_INT8, ET_UINT8:   w = 8;
            ET_INT16, ET_UINT16: w = 16;
            default:             w = 32;
        endcase
        raw[31:0] = $urandom;
        raw[32]   = $urandom_range(1);
        mask      = (33'd1 << w) - 33'd1;
        case ($urandom_range(7))
            0:       pat = '0;
            1:       pat = '1;
            2:       pat = 33'd1 << (w - 1);
            3:       pat = (33'd1 << (w - 1)) - 33'd1;
            4:       pat = 33'd1;
            5:       return fill;
            default: pat = raw;
        endcase
        return (raw & ~mask) | (pat & mask);
    endfunction

    // A fresh set of all seven registers, leaning towards the extremes.
    task automatic randomise_settings();
        logic [32:0] v;
        write_reg(CFG_TYPE, $urandom_range(7));
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = 33'h0_FFFF_FFFF;
            2:       v = $urandom_range(300);
            default: v = $urandom;
        endcase
        write_reg(CFG_LIMIT, v);
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = $urandom_range(4, 1);
            2:       v = MAXREP_RESET;
            default: v = $urandom_range(MAXREP_RESET);
        endcase
        write_reg(CFG_MAXREP, v);
        write_reg(CFG_FA_EN, $urandom_range(1));
        v[31:0] = $urandom;
        v[32]   = $urandom_range(1);
        write_reg(CFG_FA_VAL, v);
        write_reg(CFG_FB_EN, $urandom_range(1));
        v[31:0] = $urandom;
        v[32]   = $urandom_range(1);
        write_reg(CFG_FB_VAL, v);
        cfg_release();
    endtask

    // Random arrays of mostly short length, each closed by final_pair. Now and
    // then the element type changes in the middle of an array, which reloads
    // the minima and maxima but keeps the rest of the run.
    task automatic random_phase(int snd_pct, int rcv_pct, int n_pairs);
        int sent;
        int len;
        int cut;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent         = 0;
        while (sent < n_pairs) begin
            if ($urandom_range(2) == 0) begin
                settle_input();
                randomise_settings();
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
            cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : -1;
            for (int k = 0; k < len; k++) begin
                if (k == cut) begin
                    settle_input();
                    write_reg(CFG_TYPE, $urandom_range(7));
                    cfg_release();
                end
                send_pair(pick_elem(cur_fill_a), pick_elem(cur_fill_b), k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.value_a    <= '0;
        in_ch.value_b    <= '0;
        in_ch.final_pair <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_TYPE;
        cfg_ch.data      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, int32: widest signed differences in both directions,
        // with junk in bit 32 that must be dropped, then a zero difference.
        send_pair(33'h0_8000_0000, 33'h0_7FFF_FFFF, 1'b0);
        send_pair(33'h1_7FFF_FFFF, 33'h1_8000_0000, 1'b0);
        send_pair(33'h0_0000_0000, 33'h1_0000_0000, 1'b1);
        settle_input();

        // uint32 with the widest limit and no reports: the largest elements
        // saturate all three product sums at once. The type then changes to
        // int32 in the middle of the array, and a negative product has to be
        // taken off the saturated cross sum.
        write_reg(CFG_TYPE, ET_UINT32);
        write_reg(CFG_LIMIT, 33'h0_FFFF_FFFF);
        write_reg(CFG_MAXREP, '0);
        cfg_release();
        send_pair(33'h0_FFFF_FFFF, 33'h1_FFFF_FFFF, 1'b0);
        send_pair(33'h0_0000_0000, 33'h0_FFFF_FFFF, 1'b0);
        settle_input();
        write_reg(CFG_TYPE, ET_INT32);
        cfg_release();
        send_pair(33'h0_8000_0000, 33'h0_7FFF_FFFF, 1'b1);
        settle_input();

        // int8 with both fill values: a masked alone, b masked alone, both
        // masked, then two more flagged pairs; only the first flagged pair is reported.
        write_reg(CFG_TYPE, ET_INT8);
        write_reg(CFG_LIMIT, 33'd5);
        write_reg(CFG_MAXREP, 33'd1);
        write_reg(CFG_FA_EN, 33'd1);
        write_reg(CFG_FA_VAL, 33'h1_2345_6780);
        write_reg(CFG_FB_EN, 33'd1);
        write_reg(CFG_FB_VAL, 33'h0_0000_007F);
        cfg_release();
        send_pair(33'h0_0000_0080, 33'h0_0000_0005, 1'b0);
        send_pair(33'h0_0000_0003, 33'h1_FFFF_FF7F, 1'b0);
        send_pair(33'h1_FFFF_FF80, 33'h0_0000_017F, 1'b0);
        send_pair(33'h0_0000_0064, 33'h1_FFFF_FF9C, 1'b0);
        send_pair(33'h1_FFFF_FF9C, 33'h0_0000_0064, 1'b0);
        send_pair(33'h0_0000_0004, 33'h0_0000_0000, 1'b1);
        // An array whose only pair is masked on both sides: the minima and
        // maxima must come out at their reset extremes.
        send_pair(33'h0_0000_0080, 33'h0_0000_007F, 1'b1);
        settle_input();

        // The remaining types one pair each, the two spare codes included.
        write_reg(CFG_FA_EN, '0);
        write_reg(CFG_FB_EN, '0);
        write_reg(CFG_TYPE, ET_INT16);
        write_reg(CFG_LIMIT, '0);
        write_reg(CFG_MAXREP, MAXREP_RESET);
        cfg_release();
        send_pair(33'h0_0000_8000, 33'h1_0000_7FFF, 1'b1);
        settle_input();
        write_reg(CFG_TYPE, ET_UINT16);
        cfg_release();
        send_pair(33'h0_ABCD_FFFF, 33'h0_0000_0000, 1'b1);
        settle_input();
        write_reg(CFG_TYPE, TYPE_SPARE_HI);
        cfg_release();
        send_pair(33'h1_FFFF_FFFF, 33'h0_0000_0000, 1'b1);
        settle_input();
        write_reg(CFG_TYPE, TYPE_SPARE_LO);
        cfg_release();
        send_pair(33'h1_0000_0001, 33'h0_0000_0002, 1'b1);
        settle_input();
        write_reg(CFG_TYPE, ET_UINT8);
        cfg_release();
        send_pair(33'h0_0000_00FF, 33'h1_0000_0080, 1'b1);
        settle_input();

        // int32 negative products, enough of them to pin the cross sum at
        // the bottom of the signed range.
        write_reg(CFG_TYPE, ET_INT32);
        cfg_release();
        for (int n = 0; n < 5; n++) begin
            send_pair(33'h0_8000_0000, 33'h0_7FFF_FFFF, n == 4);
        end

        random_phase(16, 63, 130);
        random_phase(63, 16, 130);
        random_phase(0, 0, 130);

        settle_input();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.outstanding() == 0) begin
            $display("array_compare_statistics_core verification clean");
        end else begin
            $display("array_compare_statistics_core verification failed");
        end
        $finish;
    end

endmodule

/* array_compare_statistics_core.f */
sv/acs_pkg.sv
sv/acs_in_if.sv
sv/acs_out_if.sv
sv/acs_cfg_if.sv
sv/acs_cfg.sv
sv/acs_front.sv
sv/acs_accum.sv
sv/array_compare_statistics_core.sv
tb/sv/array_compare_statistics_core_tb.sv
